// ===== sv/assert_macros.svh =====
// Assertion macros shared by the go-back-n sender modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GBN_CHECK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// A condition that must be followed by another in the next cycle.
`define GBN_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/gbn_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package gbn_pkg;

    localparam int DEPTH        = 32;
    localparam int WINDOW       = 8;
    localparam int PACKET_BYTES = 1024;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int LEN_W        = 11;
    localparam int SEQ_W        = 32;
    localparam int TIME_W       = 32;
    localparam int LIMIT_W      = 8;
    localparam int DESC_W       = SEQ_W + LEN_W + 1;
    localparam int REG_IDX_W    = 2;

    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_FIN  = 2'd1;
    localparam logic [1:0] CMD_ACK  = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FIN_BUSY = 2'd2;
    localparam logic [1:0] ST_CLOSED   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RETRY   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ISEQ    = 2'd2;

    localparam logic [TIME_W-1:0]  TIMEOUT_RST = 32'd1000;
    localparam logic [LIMIT_W-1:0] RETRY_RST   = 8'd5;

    typedef struct packed {
        logic             latch;
        logic             push;
        logic             tick;
        logic             emit_push;
        logic             emit_rd;
        logic             emit_status;
        logic             bump_retry;
        logic             set_closed;
        logic             apply_pop;
        logic [IDX_W-1:0] rd_ofs;
        logic [1:0]       status;
        logic [CNT_W-1:0] flight;
        logic [CNT_W-1:0] pop;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0]       cmd;
        logic             len_zero;
        logic [CNT_W-1:0] count;
        logic             closed;
        logic             ack_close;
        logic             ack_above;
        logic             timed_out;
        logic             rd_fin;
        logic             retry_hit;
    } t_dp_stat;

endpackage

// ===== sv/gbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/gbn_ctrl.sv =====
// Sequencing state machine of the go-back-n sender.
`include "assert_macros.svh"

module gbn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  gbn_pkg::t_dp_stat i_stat,
    output gbn_pkg::t_dp_cmd  o_cmd
);
    import gbn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_TCHK, S_EMIT, S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_st, n_st;
    logic [CNT_W-1:0] r_flight, n_flight;
    logic [CNT_W-1:0] r_pop, n_pop;
    logic             r_close, n_close;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_base, n_base;
    logic [CNT_W-1:0] pops, over, edge_n, nxt;
    logic             scan_done, fin_close;
    t_dp_cmd          cmd;

    always_comb begin
        n_state  = r_state;
        n_st     = r_st;
        n_flight = r_flight;
        n_pop    = r_pop;
        n_close  = r_close;
        n_i      = r_i;
        n_j      = r_j;
        n_n      = r_n;
        n_base   = r_base;
        cmd      = '0;
        scan_done = 1'b0;
        pops      = r_i;
        nxt       = r_i + CNT_W'(1);
        fin_close = i_stat.rd_fin && i_stat.retry_hit;
        over      = (i_stat.count > CNT_W'(WINDOW)) ? i_stat.count - CNT_W'(WINDOW) : '0;
        edge_n    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_st     = ST_OK;
                n_flight = i_stat.count;
                n_pop    = '0;
                n_close  = 1'b0;
                n_state  = S_FINISH;
                if (i_stat.closed) begin
                    n_st = ST_CLOSED;
                end else begin
                    case (i_stat.cmd)
                        CMD_DATA: begin
                            if (i_stat.len_zero) begin
                                n_st = ST_OK;
                            end else if (i_stat.count >= CNT_W'(DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                cmd.push      = 1'b1;
                                cmd.emit_push = i_stat.count < CNT_W'(WINDOW);
                                cmd.flight    = i_stat.count + CNT_W'(1);
                                n_flight      = i_stat.count + CNT_W'(1);
                            end
                        end
                        CMD_FIN: begin
                            if (i_stat.count != '0) begin
                                n_st = ST_FIN_BUSY;
                            end else begin
                                cmd.push      = 1'b1;
                                cmd.emit_push = 1'b1;
                                cmd.flight    = CNT_W'(1);
                                n_flight      = CNT_W'(1);
                            end
                        end
                        CMD_ACK: begin
                            if (i_stat.ack_close) begin
                                n_pop    = CNT_W'(i_stat.count != '0);
                                n_close  = 1'b1;
                                n_st     = ST_CLOSED;
                                n_flight = i_stat.count - CNT_W'(i_stat.count != '0);
                            end else if (i_stat.count != '0) begin
                                n_i     = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            cmd.tick = 1'b1;
                            if (i_stat.count != '0) begin
                                n_state = S_TCHK;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The read data belongs to the entry at offset r_i from the head.
                if (i_stat.ack_above) begin
                    if (nxt == i_stat.count) begin
                        scan_done = 1'b1;
                        pops      = nxt;
                    end else begin
                        n_i        = nxt;
                        cmd.rd_ofs = nxt[IDX_W-1:0];
                    end
                end else begin
                    scan_done = 1'b1;
                    pops      = r_i;
                end
                if (scan_done) begin
                    edge_n   = (pops < over) ? pops : over;
                    n_pop    = pops;
                    n_flight = i_stat.count - pops;
                    n_base   = IDX_W'(WINDOW);
                    n_j      = '0;
                    n_n      = edge_n;
                    if (edge_n != '0) begin
                        cmd.rd_ofs = IDX_W'(WINDOW);
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_TCHK: begin
                n_state = S_FINISH;
                if (i_stat.timed_out) begin
                    cmd.bump_retry = i_stat.rd_fin;
                    n_close  = fin_close;
                    n_pop    = CNT_W'(fin_close);
                    n_flight = i_stat.count - CNT_W'(fin_close);
                    n_st     = fin_close ? ST_CLOSED : ST_OK;
                    n_n      = (i_stat.count < CNT_W'(WINDOW)) ? i_stat.count : CNT_W'(WINDOW);
                    n_base   = '0;
                    n_j      = '0;
                    cmd.rd_ofs = '0;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                cmd.emit_rd = 1'b1;
                cmd.flight  = r_flight;
                if (r_j + CNT_W'(1) < r_n) begin
                    n_j        = r_j + CNT_W'(1);
                    cmd.rd_ofs = r_base + IDX_W'(r_j + CNT_W'(1));
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.emit_status = 1'b1;
                cmd.status      = r_st;
                cmd.flight      = r_flight;
                cmd.apply_pop   = 1'b1;
                cmd.pop         = r_pop;
                cmd.set_closed  = r_close;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_st     <= n_st;
        r_flight <= n_flight;
        r_pop    <= n_pop;
        r_close  <= n_close;
        r_i      <= n_i;
        r_j      <= n_j;
        r_n      <= n_n;
        r_base   <= n_base;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

    `GBN_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, r_state == S_DISPATCH)
    `GBN_CHECK(a_emit_range, i_clk, i_rst_n, r_state != S_EMIT || r_j < r_n)
endmodule

// ===== sv/gbn_dp.sv =====
// Datapath: ring descriptors, window state, configuration and result register.
`include "assert_macros.svh"

module gbn_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gbn_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic [1:0]                    i_command,
    input  logic [gbn_pkg::LEN_W-1:0]     i_length,
    input  logic [gbn_pkg::SEQ_W-1:0]     i_ack_number,
    input  logic                          i_ack_fin,
    input  gbn_pkg::t_dp_cmd              i_cmd,
    output gbn_pkg::t_dp_stat             o_stat,
    output logic                          o_valid,
    output logic                          o_kind,
    output logic [gbn_pkg::IDX_W-1:0]     o_slot,
    output logic [gbn_pkg::SEQ_W-1:0]     o_seq,
    output logic [gbn_pkg::LEN_W-1:0]     o_pkt_length,
    output logic                          o_pkt_fin,
    output logic [1:0]                    o_status,
    output logic [gbn_pkg::CNT_W-1:0]     o_in_flight,
    output logic                          o_last
);
    import gbn_pkg::*;

    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [SEQ_W-1:0]   r_next_seq;
    logic [TIME_W-1:0]  r_now;
    logic [LIMIT_W-1:0] r_retries;
    logic               r_closed;
    logic [TIME_W-1:0]  r_timeout;
    logic [LIMIT_W-1:0] r_limit;
    logic [1:0]         r_cmd;
    logic [LEN_W-1:0]   r_len;
    logic [SEQ_W-1:0]   r_ack;
    logic               r_ack_fin;
    logic [IDX_W-1:0]   r_rd_slot;
    logic               r_valid;
    logic               r_kind, r_fin, r_last;
    logic [IDX_W-1:0]   r_slot;
    logic [SEQ_W-1:0]   r_seq;
    logic [LEN_W-1:0]   r_olen;
    logic [1:0]         r_status;
    logic [CNT_W-1:0]   r_flight;

    logic [IDX_W-1:0]   tail, rd_addr, t_waddr;
    logic [DESC_W-1:0]  desc_wdata, desc_rdata;
    logic [TIME_W-1:0]  time_rdata;
    logic [LEN_W-1:0]   push_len, clip_len;
    logic [LIMIT_W-1:0] retry_sat;
    logic               push_fin, t_we;

    assign tail      = r_head + r_count[IDX_W-1:0];
    assign rd_addr   = r_head + i_cmd.rd_ofs;
    assign push_fin  = (r_cmd == CMD_FIN);
    assign push_len  = push_fin ? '0 : r_len;
    assign desc_wdata = {r_next_seq, push_len, push_fin};
    assign t_we      = i_cmd.push || i_cmd.emit_rd;
    assign t_waddr   = i_cmd.push ? tail : r_rd_slot;
    assign clip_len  = (i_length > LEN_W'(PACKET_BYTES)) ? LEN_W'(PACKET_BYTES) : i_length;
    assign retry_sat = (r_retries == '1) ? r_retries : r_retries + LIMIT_W'(1);

    gbn_ram #(.WIDTH(DESC_W), .DEPTH(DEPTH)) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (tail),
        .i_wdata (desc_wdata),
        .i_raddr (rd_addr),
        .o_rdata (desc_rdata)
    );

    gbn_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (r_now),
        .i_raddr (rd_addr),
        .o_rdata (time_rdata)
    );

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.len_zero  = (r_len == '0);
        o_stat.count     = r_count;
        o_stat.closed    = r_closed;
        o_stat.ack_close = r_ack_fin && (r_ack == r_next_seq);
        o_stat.ack_above = r_ack > desc_rdata[DESC_W-1 -: SEQ_W];
        o_stat.timed_out = (r_now - time_rdata) >= r_timeout;
        o_stat.rd_fin    = desc_rdata[0];
        o_stat.retry_hit = retry_sat >= r_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_next_seq <= '0;
            r_now      <= '0;
            r_retries  <= '0;
            r_closed   <= 1'b0;
            r_timeout  <= TIMEOUT_RST;
            r_limit    <= RETRY_RST;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_push || i_cmd.emit_rd || i_cmd.emit_status;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TIMEOUT: r_timeout  <= i_cfg_data;
                    REG_RETRY:   r_limit    <= i_cfg_data[LIMIT_W-1:0];
                    REG_ISEQ:    r_next_seq <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                r_next_seq <= r_next_seq + SEQ_W'(1);
                r_count    <= r_count + CNT_W'(1);
            end
            if (i_cmd.apply_pop) begin
                r_head  <= r_head + i_cmd.pop[IDX_W-1:0];
                r_count <= r_count - i_cmd.pop;
            end
            if (i_cmd.tick) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_cmd.bump_retry) begin
                r_retries <= retry_sat;
            end
            if (i_cmd.set_closed) begin
                r_closed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= rd_addr;
        if (i_cmd.latch) begin
            r_cmd     <= i_command;
            r_len     <= clip_len;
            r_ack     <= i_ack_number;
            r_ack_fin <= i_ack_fin;
        end
        if (i_cmd.emit_push) begin
            r_kind   <= 1'b0;
            r_slot   <= tail;
            r_seq    <= r_next_seq;
            r_olen   <= push_len;
            r_fin    <= push_fin;
            r_status <= ST_OK;
            r_flight <= i_cmd.flight;
            r_last   <= 1'b0;
        end else if (i_cmd.emit_rd) begin
            r_kind   <= 1'b0;
            r_slot   <= r_rd_slot;
            r_seq    <= desc_rdata[DESC_W-1 -: SEQ_W];
            r_olen   <= desc_rdata[LEN_W:1];
            r_fin    <= desc_rdata[0];
            r_status <= ST_OK;
            r_flight <= i_cmd.flight;
            r_last   <= 1'b0;
        end else if (i_cmd.emit_status) begin
            r_kind   <= 1'b1;
            r_slot   <= '0;
            r_seq    <= '0;
            r_olen   <= '0;
            r_fin    <= 1'b0;
            r_status <= i_cmd.status;
            r_flight <= i_cmd.flight;
            r_last   <= 1'b1;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_slot       = r_slot;
    assign o_seq        = r_seq;
    assign o_pkt_length = r_olen;
    assign o_pkt_fin    = r_fin;
    assign o_status     = r_status;
    assign o_in_flight  = r_flight;
    assign o_last       = r_last;

    `GBN_CHECK(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `GBN_NEXT(a_closed_sticky, i_clk, i_rst_n, r_closed, r_closed)
endmodule

// ===== sv/go_back_n_sender_window.sv =====
// Go-back-n sender window over a 32-slot descriptor ring. A command is taken when start is
// high and busy is low; its results come out one per cycle on o_valid, the final one a status
// item with o_last set, and the receiver cannot stall them. Data and FIN enqueues pass through
// the dispatch and finish states, the finish state sending the status item. An acknowledgement
// that does not close the sender walks the ring from the head one entry per cycle to find what
// it retires, then sends one new window edge per cycle. A tick that times out the head resends
// up to eight window slots, one per cycle through the descriptor memory read port. No clearing
// pass follows reset.
module go_back_n_sender_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gbn_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic [1:0]                    i_command,
    input  logic [gbn_pkg::LEN_W-1:0]     i_length,
    input  logic [gbn_pkg::SEQ_W-1:0]     i_ack_number,
    input  logic                          i_ack_fin,
    output logic                          o_valid,
    output logic                          o_kind,
    output logic [gbn_pkg::IDX_W-1:0]     o_slot,
    output logic [gbn_pkg::SEQ_W-1:0]     o_seq,
    output logic [gbn_pkg::LEN_W-1:0]     o_pkt_length,
    output logic                          o_pkt_fin,
    output logic [1:0]                    o_status,
    output logic [gbn_pkg::CNT_W-1:0]     o_in_flight,
    output logic                          o_last
);
    import gbn_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    gbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    gbn_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_length     (i_length),
        .i_ack_number (i_ack_number),
        .i_ack_fin    (i_ack_fin),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_slot       (o_slot),
        .o_seq        (o_seq),
        .o_pkt_length (o_pkt_length),
        .o_pkt_fin    (o_pkt_fin),
        .o_status     (o_status),
        .o_in_flight  (o_in_flight),
        .o_last       (o_last)
    );
endmodule
